>>> rtl/core/sbct_pkg.sv
// ----------------------------------------------------------------------------
// sbct_pkg - shared types and constants of the swept box collision engine
// Beat layouts, fixed widths and the carrier that runs down the divider row.
// ----------------------------------------------------------------------------
package sbct_pkg;

    // Field widths
    localparam int CW    = 24;          // coordinate and velocity width
    localparam int TW    = 16;          // time width
    localparam int SW    = CW - 1;      // box size width
    localparam int DISTW = CW + 2;      // signed entry/exit distance width
    localparam int MAGW  = CW + 1;      // distance magnitude width
    localparam int DW    = CW + 11;     // scaled dividend and quotient width
    localparam int LANES = 4;           // x entry, x exit, y entry, y exit

    localparam int MS_PER_S = 1000;

    // Lane order
    localparam int LANE_X_IN  = 0;
    localparam int LANE_X_OUT = 1;
    localparam int LANE_Y_IN  = 2;
    localparam int LANE_Y_OUT = 3;

    // Outcome codes
    localparam logic [1:0] OUTCOME_NONE    = 2'd0;
    localparam logic [1:0] OUTCOME_OVERLAP = 2'd1;
    localparam logic [1:0] OUTCOME_CONTACT = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] box_a_left;
        logic signed [CW-1:0] box_a_top;
        logic        [SW-1:0] box_a_width;
        logic        [SW-1:0] box_a_height;
        logic signed [CW-1:0] box_b_left;
        logic signed [CW-1:0] box_b_top;
        logic        [SW-1:0] box_b_width;
        logic        [SW-1:0] box_b_height;
        logic signed [CW-1:0] rel_vel_x;
        logic signed [CW-1:0] rel_vel_y;
        logic        [TW-1:0] delta_ms;
    } item_beat_t;

    typedef struct packed {
        logic [1:0]    outcome;
        logic [TW-1:0] contact_ms;
    } result_beat_t;

    // Decision flags that ride along with the division
    typedef struct packed {
        logic             overlap;
        logic             fail;
        logic             x_unb;
        logic             y_unb;
        logic [LANES-1:0] neg;
        logic [TW-1:0]    delta;
    } side_t;

    // One restoring-division lane: partial remainder and dividend/quotient
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [DW-1:0] dq;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic  [CW-1:0]    div_x;
        logic  [CW-1:0]    div_y;
        side_t             side;
    } div_beat_t;

endpackage

>>> rtl/core/sbct_prep.sv
// ----------------------------------------------------------------------------
// sbct_prep - distance set-up and dividend scaling
// Two stages: entry/exit numerators and early rejects, then |n| * 1000.
// ----------------------------------------------------------------------------
module sbct_prep
(
    input  logic                   clk,
    input  logic                   en_a,
    input  logic                   en_b,
    input  sbct_pkg::item_beat_t   item,
    output sbct_pkg::div_beat_t    dout
);

    typedef struct packed {
        logic [sbct_pkg::LANES-1:0][sbct_pkg::DISTW-1:0] num;
        logic [sbct_pkg::CW-1:0]                         div_x;
        logic [sbct_pkg::CW-1:0]                         div_y;
        sbct_pkg::side_t                                 side;
    } prep_t;

    prep_t a_reg;
    prep_t a_next;
    sbct_pkg::div_beat_t b_reg;
    sbct_pkg::div_beat_t b_next;

    logic signed [sbct_pkg::DISTW-1:0] ax, ay, bx, by, aw, ah, bw, bh;
    logic signed [sbct_pkg::DISTW-1:0] xe, xx, ye, yx;
    logic signed [sbct_pkg::DISTW-1:0] nx_in, nx_out, ny_in, ny_out;
    logic                              vx_neg, vy_neg, vx_zero, vy_zero;
    logic                              x_span, y_span, x_fail, y_fail;

    // Stage A: distances, swap for negative velocity, rejects
    always_comb
    begin
        ax = {{2{item.box_a_left[sbct_pkg::CW-1]}}, item.box_a_left};
        ay = {{2{item.box_a_top[sbct_pkg::CW-1]}},  item.box_a_top};
        bx = {{2{item.box_b_left[sbct_pkg::CW-1]}}, item.box_b_left};
        by = {{2{item.box_b_top[sbct_pkg::CW-1]}},  item.box_b_top};
        aw = {3'b000, item.box_a_width};
        ah = {3'b000, item.box_a_height};
        bw = {3'b000, item.box_b_width};
        bh = {3'b000, item.box_b_height};

        xe = bx - ax - aw;
        xx = bx + bw - ax;
        ye = by - ay - ah;
        yx = by + bh - ay;

        vx_neg  = item.rel_vel_x[sbct_pkg::CW-1];
        vy_neg  = item.rel_vel_y[sbct_pkg::CW-1];
        vx_zero = (item.rel_vel_x == '0);
        vy_zero = (item.rel_vel_y == '0);

        // entry never exceeds exit, so spanning zero is a plain bracket
        x_span = (xe <= 0) && (xx >= 0);
        y_span = (ye <= 0) && (yx >= 0);

        nx_in  = vx_neg ? -xx : xe;
        nx_out = vx_neg ? -xe : xx;
        ny_in  = vy_neg ? -yx : ye;
        ny_out = vy_neg ? -ye : yx;

        x_fail = vx_zero ? !x_span : nx_out[sbct_pkg::DISTW-1];
        y_fail = vy_zero ? !y_span : ny_out[sbct_pkg::DISTW-1];

        a_next.num[sbct_pkg::LANE_X_IN]  = nx_in;
        a_next.num[sbct_pkg::LANE_X_OUT] = nx_out;
        a_next.num[sbct_pkg::LANE_Y_IN]  = ny_in;
        a_next.num[sbct_pkg::LANE_Y_OUT] = ny_out;
        a_next.div_x = vx_neg ? (~item.rel_vel_x + 1'b1) : item.rel_vel_x;
        a_next.div_y = vy_neg ? (~item.rel_vel_y + 1'b1) : item.rel_vel_y;
        a_next.side.overlap = x_span && y_span;
        a_next.side.fail    = (item.delta_ms == '0) || (vx_zero && vy_zero)
                              || x_fail || y_fail;
        a_next.side.x_unb   = vx_zero;
        a_next.side.y_unb   = vy_zero;
        a_next.side.neg     = '0;
        a_next.side.delta   = item.delta_ms;
    end

    // Stage B: magnitudes scaled to milliseconds
    always_comb
    begin
        logic [sbct_pkg::DISTW-1:0] mag_full;
        b_next.div_x = a_reg.div_x;
        b_next.div_y = a_reg.div_y;
        b_next.side  = a_reg.side;
        for (int i = 0; i < sbct_pkg::LANES; i++)
        begin
            mag_full = a_reg.num[i][sbct_pkg::DISTW-1] ? (~a_reg.num[i] + 1'b1)
                                                       : a_reg.num[i];
            b_next.side.neg[i]  = a_reg.num[i][sbct_pkg::DISTW-1];
            b_next.lane[i].rem  = '0;
            b_next.lane[i].dq   = sbct_pkg::DW'(mag_full[sbct_pkg::MAGW-1:0])
                                  * sbct_pkg::DW'(sbct_pkg::MS_PER_S);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_reg <= a_next;
        end
        if (en_b)
        begin
            b_reg <= b_next;
        end
    end

    assign dout = b_reg;

endmodule

>>> rtl/core/sbct_div_cell.sv
// ----------------------------------------------------------------------------
// sbct_div_cell - one restoring-division step for all four lanes
// Produces one quotient bit per lane and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module sbct_div_cell
(
    input  logic                  clk,
    input  logic                  en,
    input  sbct_pkg::div_beat_t   din,
    output sbct_pkg::div_beat_t   dout
);

    sbct_pkg::div_beat_t cell_reg;
    sbct_pkg::div_beat_t cell_next;

    // Shift in the next dividend bit, trial subtract
    always_comb
    begin
        logic [sbct_pkg::CW:0]   trial;
        logic [sbct_pkg::CW:0]   diff;
        logic [sbct_pkg::CW-1:0] dvs;
        logic                    ge;
        cell_next = din;
        for (int i = 0; i < sbct_pkg::LANES; i++)
        begin
            dvs   = (i < sbct_pkg::LANE_Y_IN) ? din.div_x : din.div_y;
            trial = {din.lane[i].rem, din.lane[i].dq[sbct_pkg::DW-1]};
            diff  = trial - {1'b0, dvs};
            ge    = (trial >= {1'b0, dvs});
            cell_next.lane[i].rem = ge ? diff[sbct_pkg::CW-1:0]
                                       : trial[sbct_pkg::CW-1:0];
            cell_next.lane[i].dq  = {din.lane[i].dq[sbct_pkg::DW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

>>> rtl/core/sbct_resolve.sv
// ----------------------------------------------------------------------------
// sbct_resolve - interval merge and result formatting
// Signs the quotients, then takes latest entry / earliest exit and decides.
// ----------------------------------------------------------------------------
module sbct_resolve
(
    input  logic                    clk,
    input  logic                    en_r1,
    input  logic                    en_out,
    input  sbct_pkg::div_beat_t     din,
    output sbct_pkg::result_beat_t  result
);

    typedef struct packed {
        logic [sbct_pkg::LANES-1:0][sbct_pkg::DW:0] t;
        sbct_pkg::side_t                            side;
    } times_t;

    times_t                 r1_reg;
    times_t                 r1_next;
    sbct_pkg::result_beat_t out_reg;
    sbct_pkg::result_beat_t out_next;

    // Signed times in ms
    always_comb
    begin
        logic [sbct_pkg::DW:0] q;
        r1_next.side = din.side;
        for (int i = 0; i < sbct_pkg::LANES; i++)
        begin
            q = {1'b0, din.lane[i].dq};
            r1_next.t[i] = din.side.neg[i] ? (~q + 1'b1) : q;
        end
    end

    // Merge the axis intervals and decide
    always_comb
    begin
        logic signed [sbct_pkg::DW:0] x_in, x_out, y_in, y_out;
        logic signed [sbct_pkg::DW:0] hit, leave, delta_s;
        x_in    = r1_reg.t[sbct_pkg::LANE_X_IN];
        x_out   = r1_reg.t[sbct_pkg::LANE_X_OUT];
        y_in    = r1_reg.t[sbct_pkg::LANE_Y_IN];
        y_out   = r1_reg.t[sbct_pkg::LANE_Y_OUT];
        delta_s = {{(sbct_pkg::DW + 1 - sbct_pkg::TW){1'b0}}, r1_reg.side.delta};

        if (r1_reg.side.x_unb)
        begin
            hit   = y_in;
            leave = y_out;
        end
        else if (r1_reg.side.y_unb)
        begin
            hit   = x_in;
            leave = x_out;
        end
        else
        begin
            hit   = (x_in > y_in)   ? x_in  : y_in;
            leave = (x_out < y_out) ? x_out : y_out;
        end

        out_next.outcome    = sbct_pkg::OUTCOME_NONE;
        out_next.contact_ms = '0;
        if (r1_reg.side.overlap)
        begin
            out_next.outcome = sbct_pkg::OUTCOME_OVERLAP;
        end
        else if (!r1_reg.side.fail && !(leave < hit) && !(hit > delta_s))
        begin
            // hit is bounded by delta above, so only the low clamp bites
            out_next.outcome    = sbct_pkg::OUTCOME_CONTACT;
            out_next.contact_ms = hit[sbct_pkg::DW] ? '0 : hit[sbct_pkg::TW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_r1)
        begin
            r1_reg <= r1_next;
        end
        if (en_out)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

>>> rtl/core/swept_box_collision_time.sv
// ----------------------------------------------------------------------------
// swept_box_collision_time - swept AABB first-contact time engine
// Streams box pairs through a row of divider cells, one pair per cycle while not stalled.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   beat
//  item      in   item_valid / item_stall     item_beat_t (two boxes, vel, step)
//  result    out  result_valid / result_stall result_beat_t (outcome, time)
//
//  One beat per cycle sustained while result_stall is low: two set-up stages,
//  CW+11 divider cells (one quotient bit each), two resolve stages. Reset
//  clears only the stage valid bits. Each stage holds while the one after it
//  is full and held, so bubbles close up under stall.
// ----------------------------------------------------------------------------
module swept_box_collision_time
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  sbct_pkg::item_beat_t    item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output sbct_pkg::result_beat_t  result
);

    localparam int NST    = sbct_pkg::DW + 4;
    localparam int ST_B   = 1;
    localparam int ST_C0  = 2;
    localparam int ST_R1  = sbct_pkg::DW + 2;
    localparam int ST_OUT = sbct_pkg::DW + 3;

    logic [NST-1:0]      vld_reg;
    logic [NST-1:0]      en;
    sbct_pkg::div_beat_t chain [sbct_pkg::DW+1];

    // Stage enables: load when empty or when the next stage moves on
    assign en[NST-1] = !vld_reg[NST-1] || !result_stall;
    for (genvar i = 0; i < NST - 1; i++)
    begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= (i == 0) ? item_valid : vld_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    assign item_stall   = !en[0];
    assign result_valid = vld_reg[ST_OUT];

    sbct_prep u_prep
    (
        .clk  (clk),
        .en_a (en[0]),
        .en_b (en[ST_B]),
        .item (item),
        .dout (chain[0])
    );

    // Divider row
    for (genvar k = 0; k < sbct_pkg::DW; k++)
    begin : g_cell
        sbct_div_cell u_cell
        (
            .clk  (clk),
            .en   (en[ST_C0 + k]),
            .din  (chain[k]),
            .dout (chain[k+1])
        );
    end

    sbct_resolve u_resolve
    (
        .clk    (clk),
        .en_r1  (en[ST_R1]),
        .en_out (en[ST_OUT]),
        .din    (chain[sbct_pkg::DW]),
        .result (result)
    );

endmodule

>>> bench/contact_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_checker - result scoreboard for the swept box collision engine
// Watches the item and result channels, predicts each pair's outcome and
// contact time, and compares every result beat in order.
// ----------------------------------------------------------------------------
module contact_checker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  sbct_pkg::item_beat_t   item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  sbct_pkg::result_beat_t result,
    output int                     fail_count,
    output int                     pending
);

    localparam longint BIG = longint'(1) << 60;

    sbct_pkg::result_beat_t expected_q[$];

    function automatic bit crosses_zero(longint e, longint x);
        return (e <= 0 && x >= 0) || (e >= 0 && x <= 0);
    endfunction

    // Per-axis entry/exit times; returns 0 when the axis can never meet
    function automatic bit axis_window(longint e, longint x, longint v,
                                       output longint t_in, output longint t_out);
        longint s;
        t_in = 0;
        t_out = 0;
        if (v == 0)
        begin
            if (!crosses_zero(e, x))
                return 0;
            t_in = -BIG;
            t_out = BIG;
            return 1;
        end
        if (v < 0)
        begin
            s = e;
            e = x;
            x = s;
        end
        if ((e < 0 && x < 0 && v > 0) || (e > 0 && x > 0 && v < 0))
            return 0;
        if ((x < 0 && v > 0) || (x > 0 && v < 0))
            return 0;
        t_in = (e * sbct_pkg::MS_PER_S) / v;
        t_out = (x * sbct_pkg::MS_PER_S) / v;
        return 1;
    endfunction

    function automatic sbct_pkg::result_beat_t predict_contact(sbct_pkg::item_beat_t b);
        sbct_pkg::result_beat_t r;
        longint xe, xx, ye, yx, xi, xo, yi, yo, hit, leave;
        r.outcome = sbct_pkg::OUTCOME_NONE;
        r.contact_ms = '0;
        xe = longint'(b.box_b_left) - (longint'(b.box_a_left) + longint'(b.box_a_width));
        xx = (longint'(b.box_b_left) + longint'(b.box_b_width)) - longint'(b.box_a_left);
        ye = longint'(b.box_b_top) - (longint'(b.box_a_top) + longint'(b.box_a_height));
        yx = (longint'(b.box_b_top) + longint'(b.box_b_height)) - longint'(b.box_a_top);
        if (crosses_zero(xe, xx) && crosses_zero(ye, yx))
        begin
            r.outcome = sbct_pkg::OUTCOME_OVERLAP;
            return r;
        end
        if (b.delta_ms == '0 || (b.rel_vel_x == '0 && b.rel_vel_y == '0))
            return r;
        if (!axis_window(xe, xx, longint'(b.rel_vel_x), xi, xo))
            return r;
        if (!axis_window(ye, yx, longint'(b.rel_vel_y), yi, yo))
            return r;
        hit = (xi > yi) ? xi : yi;
        leave = (xo < yo) ? xo : yo;
        if (leave < hit || hit > longint'(b.delta_ms))
            return r;
        if (hit < 0)
            hit = 0;
        if (hit > 65535)
            hit = 65535;
        r.outcome = sbct_pkg::OUTCOME_CONTACT;
        r.contact_ms = hit[sbct_pkg::TW-1:0];
        return r;
    endfunction

    // Predict on accepted item beats, compare on accepted result beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_q.push_back(predict_contact(item));
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat %0d/%0d", result.outcome,
                                 result.contact_ms);
                end
                else
                begin
                    if (expected_q[0] !== result)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %0d/%0d got %0d/%0d",
                                     expected_q[0].outcome, expected_q[0].contact_ms,
                                     result.outcome, result.contact_ms);
                    end
                    void'(expected_q.pop_front());
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for the swept box collision engine
// Directed corner pairs, then random near-miss and hitting geometry, with
// random gaps and stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    sbct_pkg::item_beat_t   item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    sbct_pkg::result_beat_t result;
    int                     fail_count;
    int                     pending;
    bit                     hold_off = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    swept_box_collision_time i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    contact_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [23:0] any24();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'h0;
            default: return 24'($urandom());
        endcase
    endfunction

    // Random pair: mostly plausible geometry with random velocities
    function automatic sbct_pkg::item_beat_t random_pair();
        sbct_pkg::item_beat_t b;
        logic [287:0]         raw;
        int sx, sy;
        b = '0;
        if ($urandom_range(0, 9) < 2)
        begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom()};
            b = raw[$bits(sbct_pkg::item_beat_t)-1:0];
            b.box_a_left = any24();
            b.rel_vel_x = any24();
            b.rel_vel_y = any24();
            return b;
        end
        sx = $urandom_range(0, 2) == 0 ? 8388607 : 40000;
        sy = $urandom_range(0, 2) == 0 ? 8388607 : 40000;
        b.box_a_left = 24'($signed($urandom_range(0, 2 * sx)) - sx);
        b.box_a_top = 24'($signed($urandom_range(0, 2 * sy)) - sy);
        b.box_b_left = 24'($signed($urandom_range(0, 2 * sx)) - sx);
        b.box_b_top = 24'($signed($urandom_range(0, 2 * sy)) - sy);
        b.box_a_width = 23'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 8000));
        b.box_a_height = 23'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 8000));
        b.box_b_width = 23'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 8000));
        b.box_b_height = 23'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 8000));
        b.rel_vel_x = 24'($signed($urandom_range(0, 200000)) - 100000);
        if ($urandom_range(0, 1) != 0)
            b.rel_vel_x = any24();
        if ($urandom_range(0, 5) == 0)
            b.rel_vel_x = '0;
        b.rel_vel_y = 24'($signed($urandom_range(0, 200000)) - 100000);
        if ($urandom_range(0, 1) != 0)
            b.rel_vel_y = any24();
        if ($urandom_range(0, 5) == 0)
            b.rel_vel_y = '0;
        b.delta_ms = 16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 2000));
        return b;
    endfunction

    function automatic sbct_pkg::item_beat_t pair(int al, int at, int aw, int ah,
                                                  int bl, int bt, int bw, int bh,
                                                  int vx, int vy, int d);
        sbct_pkg::item_beat_t b;
        b.box_a_left = 24'(al); b.box_a_top = 24'(at);
        b.box_a_width = 23'(aw); b.box_a_height = 23'(ah);
        b.box_b_left = 24'(bl); b.box_b_top = 24'(bt);
        b.box_b_width = 23'(bw); b.box_b_height = 23'(bh);
        b.rel_vel_x = 24'(vx); b.rel_vel_y = 24'(vy); b.delta_ms = 16'(d);
        return b;
    endfunction

    sbct_pkg::item_beat_t directed_q[$];

    // Offer one beat and hold it until accepted
    task automatic send_beat(sbct_pkg::item_beat_t b);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= b;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                result_stall <= 1'b1;
            else
                result_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        @(posedge clk);
        repeat (600) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // overlap, touching edges, zero step, no motion, one axis still,
        // separating, entry after exit, contact after step, clamp, extremes
        directed_q.push_back(pair(0, 0, 100, 100, 50, 50, 100, 100, 0, 0, 10));
        directed_q.push_back(pair(0, 0, 100, 100, 100, 0, 100, 100, 5, 0, 10));
        directed_q.push_back(pair(0, 0, 100, 100, 200, 0, 100, 100, 1000, 0, 0));
        directed_q.push_back(pair(0, 0, 100, 100, 200, 0, 100, 100, 0, 0, 100));
        directed_q.push_back(pair(0, 0, 100, 100, 200, 50, 100, 100, 1000, 0, 500));
        directed_q.push_back(pair(0, 0, 100, 100, 200, 500, 100, 100, 1000, 0, 500));
        directed_q.push_back(pair(0, 0, 100, 100, 200, 0, 100, 100, -1000, 0, 500));
        directed_q.push_back(pair(300, 0, 100, 100, 0, 0, 100, 100, -1000, 0, 500));
        directed_q.push_back(pair(0, 0, 10, 10, 1000, 2000, 10, 10, 1000, 1000, 5000));
        directed_q.push_back(pair(0, 0, 100, 100, 20000, 0, 100, 100, 10, 0, 100));
        directed_q.push_back(pair(0, 0, 1, 1, 8388607, 0, 1, 1, 1, 0, 65535));
        directed_q.push_back(pair(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
                                  8388607, 8388607, 8388607, 8388607, 65535));
        directed_q.push_back(pair(8388607, 8388607, 0, 0, -8388608, -8388608, 0, 0,
                                  -8388608, -8388608, 65535));
        directed_q.push_back(pair(-8388608, 0, 0, 0, 8388607, 0, 8388607, 0,
                                  1, -8388608, 65535));
        directed_q.push_back(pair(0, 0, 100, 100, 50, 1000, 10, 10, 0, 300, 65535));
        directed_q.push_back(pair(0, 0, 100, 100, 1000, 1000, 10, 10, -1, 1, 65535));
        foreach (directed_q[i])
            send_beat(directed_q[i]);
        for (k = 0; k < 1900; k++)
            send_beat(random_pair());
        item_valid <= 1'b0;
        // let the scoreboard count the last accepted beat
        @(posedge clk);
        while (pending != 0 || hold_off) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
